// ===== design/pcm_to_float_mono_downmix_unit_assert.svh =====
// Assertion macros used by the checker file pcmf_chk.sv.
`ifndef PCM_TO_FLOAT_MONO_DOWNMIX_UNIT_ASSERT_SVH
`define PCM_TO_FLOAT_MONO_DOWNMIX_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define PCMF_AST_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcmf check failed");

// next-cycle implication, quiet while reset is high
`define PCMF_AST_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcmf check failed");

`endif

// ===== design/pcmf_pkg.sv =====
`timescale 1ns / 1ps
package pcmf_pkg;

   // sample format codes
   localparam logic [2:0] FMT_U8  = 3'd0;
   localparam logic [2:0] FMT_S16 = 3'd1;
   localparam logic [2:0] FMT_S32 = 3'd2;
   localparam logic [2:0] FMT_F32 = 3'd3;
   localparam logic [2:0] FMT_F64 = 3'd4;

   // channel counts
   localparam logic [1:0] CHAN_STEREO = 2'd2;

   // register indexes (paddr bit 2)
   localparam logic REG_FORMAT   = 1'b0;
   localparam logic REG_CHANNELS = 1'b1;

   localparam logic [2:0] FORMAT_RESET   = FMT_F32;
   localparam logic [1:0] CHANNELS_RESET = CHAN_STEREO;

   // IEEE single constants
   localparam logic [31:0] QNAN_BIT    = 32'h0040_0000;
   localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
   localparam logic [7:0]  EXP_MAX     = 8'hFF;

endpackage

// ===== design/pcmf_cvt.sv =====
`timescale 1ns / 1ps
// Converts one raw PCM sample to a single-precision bit pattern.
module pcmf_cvt (
   input  logic [2:0]  fmt,
   input  logic [63:0] raw,
   output logic [31:0] fbits
);
   import pcmf_pkg::*;

   // integer path
   logic [31:0] sval;
   logic [4:0]  kscale;
   logic        ineg;
   logic [31:0] mag;
   logic [4:0]  lz;
   logic        found;
   logic [31:0] norm;
   logic [8:0]  iexp;
   logic        irnd;
   logic [30:0] ibody;
   logic [31:0] ibits;

   always_comb begin
      case (fmt)
         FMT_U8: begin
            sval   = {24'd0, raw[7:0]} - 32'd128;
            kscale = 5'd7;
         end
         FMT_S16: begin
            sval   = {{16{raw[15]}}, raw[15:0]};
            kscale = 5'd15;
         end
         default: begin
            sval   = raw[31:0];
            kscale = 5'd31;
         end
      endcase
      ineg = sval[31];
      mag  = ineg ? (32'd0 - sval) : sval;
      // leading zero count
      lz    = 5'd0;
      found = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (!found && mag[i]) begin
            found = 1'b1;
            lz    = 5'(31 - i);
         end
      end
      norm  = mag << lz;
      iexp  = 9'd158 - {4'd0, lz} - {4'd0, kscale};
      irnd  = norm[7] & ((|norm[6:0]) | norm[8]);
      ibody = {iexp[7:0], norm[30:8]} + {30'd0, irnd};
      ibits = (mag == 32'd0) ? 32'd0 : {ineg, ibody};
   end

   // double to single path
   logic        dsign;
   logic [10:0] dexp;
   logic [51:0] dman;
   logic [52:0] dm;
   logic [7:0]  ne;
   logic        nrnd;
   logic [30:0] nbody;
   logic [10:0] dsh;
   logic [107:0] dext;
   logic        srnd;
   logic [30:0] sbody;
   logic [31:0] dbits;

   always_comb begin
      dsign = raw[63];
      dexp  = raw[62:52];
      dman  = raw[51:0];
      dm    = {1'b1, dman};
      ne    = 8'(dexp - 11'd896);
      nrnd  = dm[28] & ((|dm[27:0]) | dm[29]);
      nbody = {ne, dm[51:29]} + {30'd0, nrnd};
      dsh   = 11'd926 - dexp;
      dext  = {dm, 55'd0} >> dsh[5:0];
      srnd  = dext[54] & ((|dext[53:0]) | dext[55]);
      sbody = {8'd0, dext[77:55]} + {30'd0, srnd};
      if (dexp == 11'h7FF) begin
         if (dman == 52'd0) dbits = {dsign, EXP_MAX, 23'd0};
         else dbits = {dsign, EXP_MAX, 1'b1, dman[50:29]};
      end else if (dexp == 11'd0) begin
         dbits = {dsign, 31'd0};
      end else if (dexp >= 11'd1151) begin
         dbits = {dsign, EXP_MAX, 23'd0};
      end else if (dexp >= 11'd897) begin
         dbits = {dsign, nbody};
      end else if (dexp < 11'd872) begin
         dbits = {dsign, 31'd0};
      end else begin
         dbits = {dsign, sbody};
      end
   end

   // format select
   always_comb begin
      case (fmt)
         FMT_U8, FMT_S16, FMT_S32: fbits = ibits;
         FMT_F32:                  fbits = raw[31:0];
         FMT_F64:                  fbits = dbits;
         default:                  fbits = 32'd0;
      endcase
   end

endmodule

// ===== design/pcm_to_float_mono_downmix_unit.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Payload
// req      in         tdata[63:0] left_raw, tdata[127:64] right_raw
// rsp      out        tdata[31:0] mono_sample
// csr      in/out     APB, 0x0 sample_format, 0x4 channel_count
//
// Five register stages: convert, align, add, normalize/round, halve/select.
// One request per cycle unless the output stalls.
// Each stage advances when it is empty or the next one advances, so bubbles
// close up under a stall and nothing is lost or repeated.
// Synchronous reset clears valid bits and both registers (format 3, stereo).
module pcm_to_float_mono_downmix_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] left_raw, [127:64] right_raw
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [31:0] mono_sample
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import pcmf_pkg::*;

   // configuration registers
   logic [2:0] fmt_ff;
   logic [1:0] chan_ff;
   logic       csr_wr;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= FORMAT_RESET;
         chan_ff <= CHANNELS_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_FORMAT) fmt_ff <= csr_pwdata[2:0];
         else chan_ff <= csr_pwdata[1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_CHANNELS) csr_prdata = {30'd0, chan_ff};
      else csr_prdata = {29'd0, fmt_ff};
   end

   // stage handshake
   logic [4:0] vld_ff;
   logic [4:0] adv;

   always_comb begin
      adv[4] = !vld_ff[4] || rsp_tready;
      for (int i = 3; i >= 0; i--) adv[i] = !vld_ff[i] || adv[i+1];
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 5'd0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_tvalid;
         for (int i = 1; i < 5; i++) if (adv[i]) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage 1: convert both channels
   logic [31:0] lc, rc;
   logic [31:0] l1_ff, r1_ff;
   logic        mix1_ff;

   pcmf_cvt u_cvt_left  (.fmt(fmt_ff), .raw(req_tdata[63:0]),   .fbits(lc));
   pcmf_cvt u_cvt_right (.fmt(fmt_ff), .raw(req_tdata[127:64]), .fbits(rc));

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         l1_ff   <= lc;
         r1_ff   <= rc;
         mix1_ff <= (chan_ff == CHAN_STEREO);
      end
   end

   // stage 2: special cases, swap and align
   logic        l_nan, r_nan, l_inf, r_inf;
   logic        byp_in;
   logic [31:0] bypv_in;
   logic        a_big;
   logic [31:0] fb, fs;
   logic [7:0]  eb, es;
   logic [23:0] sb, ss;
   logic [7:0]  dexp;
   logic [4:0]  dd;
   logic [53:0] sext;
   logic [26:0] sml_in;

   logic        byp2_ff, sub2_ff, sgn2_ff, sand2_ff;
   logic [31:0] bypv2_ff;
   logic [7:0]  exp2_ff;
   logic [26:0] big2_ff, sml2_ff;

   always_comb begin
      l_nan = (l1_ff[30:23] == EXP_MAX) && (l1_ff[22:0] != 23'd0);
      r_nan = (r1_ff[30:23] == EXP_MAX) && (r1_ff[22:0] != 23'd0);
      l_inf = (l1_ff[30:0] == {EXP_MAX, 23'd0});
      r_inf = (r1_ff[30:0] == {EXP_MAX, 23'd0});
      byp_in  = 1'b1;
      bypv_in = l1_ff;
      if (!mix1_ff) bypv_in = l1_ff;
      else if (l_nan) bypv_in = l1_ff | QNAN_BIT;
      else if (r_nan) bypv_in = r1_ff | QNAN_BIT;
      else if (l_inf && r_inf && (l1_ff[31] != r1_ff[31])) bypv_in = DEFAULT_NAN;
      else if (l_inf) bypv_in = l1_ff;
      else if (r_inf) bypv_in = r1_ff;
      else byp_in = 1'b0;
      // larger magnitude first
      a_big = (l1_ff[30:0] >= r1_ff[30:0]);
      fb    = a_big ? l1_ff : r1_ff;
      fs    = a_big ? r1_ff : l1_ff;
      eb    = (fb[30:23] == 8'd0) ? 8'd1 : fb[30:23];
      es    = (fs[30:23] == 8'd0) ? 8'd1 : fs[30:23];
      sb    = {(fb[30:23] != 8'd0), fb[22:0]};
      ss    = {(fs[30:23] != 8'd0), fs[22:0]};
      dexp  = eb - es;
      dd    = (dexp > 8'd26) ? 5'd27 : dexp[4:0];
      sext  = {ss, 3'd0, 27'd0} >> dd;
      sml_in = {sext[53:28], sext[27] | (|sext[26:0])};
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         byp2_ff  <= byp_in;
         bypv2_ff <= bypv_in;
         sub2_ff  <= l1_ff[31] ^ r1_ff[31];
         sgn2_ff  <= fb[31];
         sand2_ff <= l1_ff[31] & r1_ff[31];
         exp2_ff  <= eb;
         big2_ff  <= {sb, 3'd0};
         sml2_ff  <= sml_in;
      end
   end

   // stage 3: add or subtract, count leading zeros
   logic [27:0] sum_in;
   logic [4:0]  lz_in;
   logic        lz_found;

   logic        byp3_ff, sgn3_ff, sand3_ff;
   logic [31:0] bypv3_ff;
   logic [7:0]  exp3_ff;
   logic [27:0] sum3_ff;
   logic [4:0]  lz3_ff;

   always_comb begin
      sum_in = sub2_ff ? ({1'b0, big2_ff} - {1'b0, sml2_ff})
                       : ({1'b0, big2_ff} + {1'b0, sml2_ff});
      lz_in    = 5'd28;
      lz_found = 1'b0;
      for (int i = 27; i >= 0; i--) begin
         if (!lz_found && sum_in[i]) begin
            lz_found = 1'b1;
            lz_in    = 5'(27 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         byp3_ff  <= byp2_ff;
         bypv3_ff <= bypv2_ff;
         sgn3_ff  <= sgn2_ff;
         sand3_ff <= sand2_ff;
         exp3_ff  <= exp2_ff;
         sum3_ff  <= sum_in;
         lz3_ff   <= lz_in;
      end
   end

   // stage 4: normalize and round the sum to single
   logic [7:0]  lzm1, em1, nsh;
   logic [26:0] m27;
   logic [8:0]  eout;
   logic [7:0]  efield;
   logic        srnd;
   logic [31:0] rbody;
   logic [31:0] sum_bits;

   logic        byp4_ff;
   logic [31:0] bypv4_ff, sum4_ff;

   always_comb begin
      lzm1 = {3'd0, lz3_ff} - 8'd1;
      em1  = exp3_ff - 8'd1;
      nsh  = (lzm1 < em1) ? lzm1 : em1;
      if (sum3_ff[27]) begin
         m27  = {sum3_ff[27:2], sum3_ff[1] | sum3_ff[0]};
         eout = {1'b0, exp3_ff} + 9'd1;
      end else begin
         m27  = sum3_ff[26:0] << nsh[4:0];
         eout = {1'b0, exp3_ff} - {1'b0, nsh};
      end
      efield = m27[26] ? eout[7:0] : 8'd0;
      srnd   = m27[2] & (m27[1] | m27[0] | m27[3]);
      rbody  = {1'b0, efield, m27[25:3]} + {31'd0, srnd};
      if (sum3_ff == 28'd0) sum_bits = {sand3_ff, 31'd0};
      else if (eout >= 9'd255 && m27[26]) sum_bits = {sgn3_ff, EXP_MAX, 23'd0};
      else sum_bits = {sgn3_ff, rbody[30:0]};
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         byp4_ff  <= byp3_ff;
         bypv4_ff <= bypv3_ff;
         sum4_ff  <= sum_bits;
      end
   end

   // stage 5: halve, select the result
   logic [7:0]  he;
   logic [23:0] hsig;
   logic        hrnd;
   logic [30:0] hbody;
   logic [31:0] half_bits;
   logic [31:0] out_ff;

   always_comb begin
      he    = sum4_ff[30:23];
      hsig  = {he[0], sum4_ff[22:0]};
      hrnd  = hsig[0] & hsig[1];
      hbody = {8'd0, hsig[23:1]} + {30'd0, hrnd};
      if (he == EXP_MAX) half_bits = sum4_ff;
      else if (he >= 8'd2) half_bits = {sum4_ff[31], he - 8'd1, sum4_ff[22:0]};
      else half_bits = {sum4_ff[31], hbody};
   end

   always_ff @(posedge clock) begin
      if (adv[4]) out_ff <= byp4_ff ? bypv4_ff : half_bits;
   end

   assign rsp_tdata = out_ff;

endmodule

// ===== design/pcmf_chk.sv =====
`timescale 1ns / 1ps
`include "pcm_to_float_mono_downmix_unit_assert.svh"
// Port-level checks on the downmix unit.
module pcmf_chk (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic         csr_psel,
   input logic         csr_penable,
   input logic         csr_pready
);
   // a waiting result stays
   `PCMF_AST_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // and its data does not move
   `PCMF_AST_NEXT(a_rsp_data_hold, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // pipeline only backs up when the output is stalled
   `PCMF_AST_IMPL(a_backpressure, !req_tready, rsp_tvalid && !rsp_tready)
   // no result right out of reset
   `PCMF_AST_IMPL(a_reset_empty, $past(reset), !rsp_tvalid)
   // register port never waits
   `PCMF_AST_IMPL(a_csr_ready, csr_psel && csr_penable, csr_pready)
endmodule

bind pcm_to_float_mono_downmix_unit pcmf_chk u_pcmf_chk (.*);
